// ----- rtl/llss_pkg.sv -----
// Package for the linked list sequence store: request and status codes,
// sequencer states and shared constants. No dependencies.
`default_nettype none
package llss_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam logic [6:0] NIL = 7'h7F;

    typedef enum logic [3:0] {
        REQ_INS_FRONT = 4'd0,
        REQ_INS_REAR  = 4'd1,
        REQ_LIST      = 4'd2,
        REQ_COUNT     = 4'd3,
        REQ_DEL_VALUE = 4'd4,
        REQ_DEL_REAR  = 4'd5,
        REQ_DEL_FRONT = 4'd6,
        REQ_INS_AFTER = 4'd7,
        REQ_REVERSE   = 4'd8
    } t_req;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_STEP,
        S_WRITE,
        S_LREAD,
        S_LWAIT,
        S_LOUT,
        S_OUT
    } t_state;

    // Memory access request from the sequencer to the node store.
    typedef struct packed {
        logic        rd_en;
        logic [5:0]  rd_addr;
        logic        wr_data_en;
        logic        wr_next_en;
        logic [5:0]  wr_addr;
        logic [31:0] wr_data;
        logic [6:0]  wr_next;
    } t_mem_req;
endpackage
`default_nettype wire

// ----- rtl/llss_node_store.sv -----
// Node store: data and next-link memories with a registered read port.
// Depends on llss_pkg for the request struct.
`default_nettype none
module llss_node_store #(
    parameter int CAPACITY = llss_pkg::CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire llss_pkg::t_mem_req i_req,
    output logic [31:0]            o_rd_data,
    output logic [6:0]             o_rd_next
);
    localparam int AW = $clog2(CAPACITY);
    logic [31:0] r_data [CAPACITY];
    logic [6:0]  r_next [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_data_en) r_data[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        if (i_req.wr_next_en) r_next[i_req.wr_addr[AW-1:0]] <= i_req.wr_next;
        if (i_req.rd_en) begin
            o_rd_data <= r_data[i_req.rd_addr[AW-1:0]];
            o_rd_next <= r_next[i_req.rd_addr[AW-1:0]];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/linked_list_sequence_store.sv -----
// Top level of the linked list sequence store: free map, list pointers and
// the walk sequencer. Depends on llss_pkg and llss_node_store.
//
//  channel | valid   | ready   | payload
//  input   | i_valid | o_ready | i_req_type, i_elem_value, i_anchor_value
//  output  | o_valid | i_ready | o_out_value, o_status, o_node_total, o_last_flag
//
// One transaction is worked at a time. A walk visits each node with a read,
// a wait for the memory and a step, set by the single read port of the node
// store; front inserts and count need no walk, and a listing reads, waits
// for and emits each element and pauses while the output stalls. Reset
// clears head, tail, count and the free map. The output register holds a
// result until taken; the sequencer waits on it while the consumer stalls.
`default_nettype none
module linked_list_sequence_store #(
    parameter int CAPACITY = llss_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [3:0]         i_req_type,
    input  wire logic signed [31:0] i_elem_value,
    input  wire logic signed [31:0] i_anchor_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_out_value,
    output logic [1:0]              o_status,
    output logic [6:0]              o_node_total,
    output logic                    o_last_flag
);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [6:0] CAP7 = 7'(CAPACITY);
    localparam logic [6:0] NIL_C = llss_pkg::NIL;

    llss_pkg::t_state   r_state, n_state;
    llss_pkg::t_mem_req s_mem;
    logic [31:0] s_rd_data;
    logic [6:0]  s_rd_next;

    logic [CAPACITY-1:0] r_free, n_free;
    logic [6:0] r_head, n_head, r_tail, n_tail, r_count, n_count;
    logic [3:0] r_req, n_req;
    logic [31:0] r_ev, n_ev, r_av, n_av;
    logic [6:0] r_cur, n_cur, r_prev, n_prev;
    logic [6:0] r_steps, n_steps;
    logic       r_rev, n_rev; // reversing pass before a listing
    logic [31:0] r_oval, n_oval;
    logic [1:0]  r_ost, n_ost;
    logic        r_olast, n_olast, r_ovalid, n_ovalid;

    // Lowest free node, a priority search over the free map.
    logic [6:0] s_free_idx;
    always_comb begin
        s_free_idx = NIL_C;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (r_free[i]) s_free_idx = 7'(i);
    end

    function automatic logic is_nil(input logic [6:0] p);
        return p >= CAP7;
    endfunction

    llss_node_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk(i_clk), .i_req(s_mem), .o_rd_data(s_rd_data), .o_rd_next(s_rd_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= llss_pkg::S_IDLE;
            r_free   <= '1;
            r_head   <= NIL_C;
            r_tail   <= NIL_C;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_req <= n_req; r_ev <= n_ev; r_av <= n_av; r_cur <= n_cur;
        r_prev <= n_prev; r_steps <= n_steps; r_rev <= n_rev;
        r_oval <= n_oval; r_ost <= n_ost; r_olast <= n_olast;
    end

    assign o_ready      = (r_state == llss_pkg::S_IDLE) && !r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_out_value  = r_oval;
    assign o_status     = r_ost;
    assign o_node_total = r_count;
    assign o_last_flag  = r_olast;

    always_comb begin
        logic empty, full, done;
        empty = is_nil(r_head);
        full  = r_count >= CAP7;
        done  = 1'b0;
        n_state = r_state; n_free = r_free; n_head = r_head; n_tail = r_tail;
        n_count = r_count; n_req = r_req; n_ev = r_ev; n_av = r_av;
        n_cur = r_cur; n_prev = r_prev; n_steps = r_steps; n_rev = r_rev;
        n_oval = r_oval; n_ost = r_ost; n_olast = r_olast;
        n_ovalid = r_ovalid && !i_ready;
        s_mem = '0;
        unique case (r_state)
            llss_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_req = i_req_type; n_ev = i_elem_value; n_av = i_anchor_value;
                    n_cur = r_head; n_prev = NIL_C; n_steps = '0;
                    n_oval = '0; n_olast = 1'b1; n_ost = llss_pkg::ST_OK;
                    n_state = llss_pkg::S_OUT;
                    unique case (i_req_type)
                        llss_pkg::REQ_INS_FRONT, llss_pkg::REQ_INS_REAR,
                        llss_pkg::REQ_INS_AFTER: begin
                            if (full) n_ost = llss_pkg::ST_FULL;
                            else if (i_req_type == llss_pkg::REQ_INS_FRONT || empty) begin
                                s_mem.wr_data_en = 1'b1; s_mem.wr_next_en = 1'b1;
                                s_mem.wr_addr = s_free_idx[5:0];
                                s_mem.wr_data = i_elem_value;
                                s_mem.wr_next = empty ? NIL_C : r_head;
                                n_free[s_free_idx[AW-1:0]] = 1'b0;
                                n_count = r_count + 7'd1;
                                n_head = s_free_idx;
                                if (empty) n_tail = s_free_idx;
                            end else if (i_req_type == llss_pkg::REQ_INS_REAR) begin
                                s_mem.wr_data_en = 1'b1; s_mem.wr_next_en = 1'b1;
                                s_mem.wr_addr = s_free_idx[5:0];
                                s_mem.wr_data = i_elem_value; s_mem.wr_next = NIL_C;
                                n_free[s_free_idx[AW-1:0]] = 1'b0;
                                n_count = r_count + 7'd1;
                                n_prev = s_free_idx;
                                n_state = llss_pkg::S_WRITE; // link old tail
                            end else n_state = llss_pkg::S_READ;
                        end
                        llss_pkg::REQ_COUNT: ;
                        llss_pkg::REQ_LIST, llss_pkg::REQ_REVERSE: begin
                            if (empty) n_ost = llss_pkg::ST_EMPTY;
                            else begin
                                n_rev = i_req_type == llss_pkg::REQ_REVERSE;
                                n_state = n_rev ? llss_pkg::S_READ : llss_pkg::S_LREAD;
                            end
                        end
                        llss_pkg::REQ_DEL_VALUE, llss_pkg::REQ_DEL_REAR,
                        llss_pkg::REQ_DEL_FRONT: begin
                            if (empty) n_ost = llss_pkg::ST_EMPTY;
                            else n_state = llss_pkg::S_READ;
                        end
                        default: n_state = llss_pkg::S_IDLE;
                    endcase
                end
            end
            llss_pkg::S_READ: begin
                s_mem.rd_en = 1'b1; s_mem.rd_addr = r_cur[5:0];
                n_state = llss_pkg::S_WAIT;
            end
            llss_pkg::S_WAIT: n_state = llss_pkg::S_STEP;
            llss_pkg::S_STEP: begin
                n_steps = r_steps + 7'd1;
                n_state = llss_pkg::S_READ;
                unique case (r_req)
                    llss_pkg::REQ_DEL_FRONT: begin
                        n_oval = s_rd_data; n_head = s_rd_next;
                        if (is_nil(s_rd_next)) n_tail = NIL_C;
                        n_free[r_cur[AW-1:0]] = 1'b1; n_count = r_count - 7'd1;
                        n_state = llss_pkg::S_OUT;
                    end
                    llss_pkg::REQ_DEL_REAR: begin
                        if (is_nil(s_rd_next) || n_steps >= CAP7) begin
                            n_oval = s_rd_data;
                            if (is_nil(r_prev)) n_head = NIL_C;
                            else begin
                                s_mem.wr_next_en = 1'b1; s_mem.wr_addr = r_prev[5:0];
                                s_mem.wr_next = NIL_C;
                            end
                            n_tail = r_prev;
                            n_free[r_cur[AW-1:0]] = 1'b1; n_count = r_count - 7'd1;
                            n_state = llss_pkg::S_OUT;
                        end else begin
                            n_prev = r_cur; n_cur = s_rd_next;
                        end
                    end
                    llss_pkg::REQ_DEL_VALUE: begin
                        if (s_rd_data == r_ev) begin
                            n_oval = s_rd_data;
                            if (is_nil(r_prev)) n_head = s_rd_next;
                            else begin
                                s_mem.wr_next_en = 1'b1; s_mem.wr_addr = r_prev[5:0];
                                s_mem.wr_next = s_rd_next;
                            end
                            if (r_cur == r_tail) n_tail = r_prev;
                            n_free[r_cur[AW-1:0]] = 1'b1; n_count = r_count - 7'd1;
                            n_state = llss_pkg::S_OUT;
                        end else begin
                            n_prev = r_cur; n_cur = s_rd_next;
                            done = is_nil(s_rd_next) || n_steps >= CAP7;
                            if (done) begin
                                n_ost = llss_pkg::ST_NOTFOUND; n_state = llss_pkg::S_OUT;
                            end
                        end
                    end
                    llss_pkg::REQ_INS_AFTER: begin
                        if (s_rd_data == r_av) begin
                            s_mem.wr_data_en = 1'b1; s_mem.wr_next_en = 1'b1;
                            s_mem.wr_addr = s_free_idx[5:0];
                            s_mem.wr_data = r_ev; s_mem.wr_next = s_rd_next;
                            n_free[s_free_idx[AW-1:0]] = 1'b0;
                            n_count = r_count + 7'd1;
                            if (r_cur == r_tail) n_tail = s_free_idx;
                            n_prev = s_free_idx;
                            n_state = llss_pkg::S_WRITE;
                        end else begin
                            n_cur = s_rd_next;
                            if (is_nil(s_rd_next) || n_steps >= CAP7) begin
                                n_ost = llss_pkg::ST_NOTFOUND; n_state = llss_pkg::S_OUT;
                            end
                        end
                    end
                    default: begin // reverse pass
                        s_mem.wr_next_en = 1'b1; s_mem.wr_addr = r_cur[5:0];
                        s_mem.wr_next = r_prev;
                        n_prev = r_cur; n_cur = s_rd_next;
                        if (is_nil(s_rd_next) || n_steps >= CAP7) begin
                            n_tail = r_head; n_head = r_cur; n_cur = r_cur;
                            n_steps = '0; n_state = llss_pkg::S_LREAD;
                        end
                    end
                endcase
            end
            llss_pkg::S_WRITE: begin
                // Link the anchor or old tail to the node just taken.
                s_mem.wr_next_en = 1'b1;
                s_mem.wr_addr = (r_req == llss_pkg::REQ_INS_REAR) ? r_tail[5:0] : r_cur[5:0];
                s_mem.wr_next = r_prev;
                if (r_req == llss_pkg::REQ_INS_REAR) n_tail = r_prev;
                n_state = llss_pkg::S_OUT;
            end
            llss_pkg::S_LREAD: begin
                if (!r_ovalid) begin
                    s_mem.rd_en = 1'b1; s_mem.rd_addr = r_cur[5:0];
                    n_state = llss_pkg::S_LWAIT;
                end
            end
            llss_pkg::S_LWAIT: n_state = llss_pkg::S_LOUT;
            llss_pkg::S_LOUT: begin
                n_steps = r_steps + 7'd1;
                n_oval = s_rd_data; n_ost = llss_pkg::ST_OK;
                n_olast = is_nil(s_rd_next) || n_steps >= CAP7;
                n_ovalid = 1'b1; n_cur = s_rd_next;
                n_state = n_olast ? llss_pkg::S_IDLE : llss_pkg::S_LREAD;
            end
            llss_pkg::S_OUT: begin
                n_ovalid = 1'b1; n_state = llss_pkg::S_IDLE;
            end
            default: n_state = llss_pkg::S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP7) else $error("node count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == is_nil(r_head) || r_state != llss_pkg::S_IDLE)
        else $error("count and head disagree");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_value))
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_nil(r_head) == is_nil(r_tail) || r_state != llss_pkg::S_IDLE)
        else $error("head and tail disagree");
endmodule
`default_nettype wire

// ----- sim/linked_list_sequence_store_checker.sv -----
// Checker for the linked list sequence store: watches both channels, keeps
// its own model of the list and compares every result. Depends on llss_pkg.
`timescale 1ns / 100ps
module linked_list_sequence_store_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_in_ready,
    input  wire logic [3:0]         i_req_type,
    input  wire logic signed [31:0] i_elem_value,
    input  wire logic signed [31:0] i_anchor_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_ready,
    input  wire logic signed [31:0] i_out_value,
    input  wire logic [1:0]         i_status,
    input  wire logic [6:0]         i_node_total,
    input  wire logic               i_last_flag,
    output int                      o_fail_count,
    output int                      o_pending
);
    localparam int CAP = llss_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic [6:0]  total;
        logic        last;
    } t_result;

    // The list is kept as an ordered queue of values; node placement in the
    // store is invisible from outside.
    logic [31:0] seq_values[$];
    t_result     expected_results[$];

    assign o_pending = expected_results.size();

    task automatic push_result(input logic [31:0] v, input logic [1:0] st,
                               input logic last);
        t_result r;
        r.value = v;
        r.status = st;
        r.total = 7'(seq_values.size());
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic push_listing();
        int n;
        n = seq_values.size();
        if (n == 0) begin
            push_result('0, llss_pkg::ST_EMPTY, 1'b1);
        end else begin
            for (int i = 0; i < n; i++)
                push_result(seq_values[i], llss_pkg::ST_OK, i == n - 1);
        end
    endtask

    task automatic predict_request(input logic [3:0] req, input logic [31:0] ev,
                                   input logic [31:0] av);
        int idx;
        logic [31:0] v;
        logic [31:0] flipped[$];
        idx = -1;
        case (req)
            llss_pkg::REQ_INS_FRONT, llss_pkg::REQ_INS_REAR,
            llss_pkg::REQ_INS_AFTER: begin
                if (seq_values.size() >= CAP) begin
                    push_result('0, llss_pkg::ST_FULL, 1'b1);
                end else if (req == llss_pkg::REQ_INS_FRONT) begin
                    seq_values.push_front(ev);
                    push_result('0, llss_pkg::ST_OK, 1'b1);
                end else if (req == llss_pkg::REQ_INS_REAR || seq_values.size() == 0) begin
                    seq_values.push_back(ev);
                    push_result('0, llss_pkg::ST_OK, 1'b1);
                end else begin
                    for (int i = 0; i < seq_values.size(); i++)
                        if (idx < 0 && seq_values[i] == av) idx = i;
                    if (idx < 0) begin
                        push_result('0, llss_pkg::ST_NOTFOUND, 1'b1);
                    end else begin
                        seq_values.insert(idx + 1, ev);
                        push_result('0, llss_pkg::ST_OK, 1'b1);
                    end
                end
            end
            llss_pkg::REQ_LIST: push_listing();
            llss_pkg::REQ_COUNT: push_result('0, llss_pkg::ST_OK, 1'b1);
            llss_pkg::REQ_DEL_VALUE, llss_pkg::REQ_DEL_REAR,
            llss_pkg::REQ_DEL_FRONT: begin
                if (seq_values.size() == 0) begin
                    push_result('0, llss_pkg::ST_EMPTY, 1'b1);
                end else begin
                    if (req == llss_pkg::REQ_DEL_FRONT) idx = 0;
                    else if (req == llss_pkg::REQ_DEL_REAR) idx = seq_values.size() - 1;
                    else
                        for (int i = 0; i < seq_values.size(); i++)
                            if (idx < 0 && seq_values[i] == ev) idx = i;
                    if (idx < 0) begin
                        push_result('0, llss_pkg::ST_NOTFOUND, 1'b1);
                    end else begin
                        v = seq_values[idx];
                        seq_values.delete(idx);
                        push_result(v, llss_pkg::ST_OK, 1'b1);
                    end
                end
            end
            llss_pkg::REQ_REVERSE: begin
                foreach (seq_values[i]) flipped.push_front(seq_values[i]);
                seq_values = flipped;
                push_listing();
            end
            default: ;  // Unknown codes are dropped without a result.
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            // The result side is checked first so that a request accepted in
            // the same edge cannot push ahead of it; it never affects order.
            if (i_out_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out_value !== exp_r.value)
                        report_mismatch($sformatf("out_value %h, expected %h",
                                                  i_out_value, exp_r.value));
                    if (i_status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, exp_r.status));
                    if (i_node_total !== exp_r.total)
                        report_mismatch($sformatf("node_total %0d, expected %0d",
                                                  i_node_total, exp_r.total));
                    if (i_last_flag !== exp_r.last)
                        report_mismatch($sformatf("last_flag %0d, expected %0d",
                                                  i_last_flag, exp_r.last));
                end
            end
            if (i_valid && i_in_ready)
                predict_request(i_req_type, i_elem_value, i_anchor_value);
        end
    end
endmodule

// ----- sim/linked_list_sequence_store_test.sv -----
// Testbench top for the linked list sequence store: clock, reset, request
// stimulus, consumer stalls and the verdict. Depends on llss_pkg, the block
// and linked_list_sequence_store_checker.
`timescale 1ns / 100ps
module linked_list_sequence_store_test;
    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [3:0]         req_type;
    logic signed [31:0] req_elem;
    logic signed [31:0] req_anchor;
    logic               res_valid;
    logic               res_ready;
    logic signed [31:0] res_value;
    logic [1:0]         res_status;
    logic [6:0]         res_total;
    logic               res_last;
    int                 fail_count;
    int                 pending;

    // While set, the consumer holds i_ready low for a long stretch so that
    // the block backs up and stops taking requests.
    logic               hold_consumer;
    event               start_hold;

    // A small pool of values makes searches hit often; the rest are random
    // over the full 32-bit range.
    logic [31:0]        value_pool[8];

    initial begin
        value_pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555, 32'h2A};
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    linked_list_sequence_store uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_req_type(req_type), .i_elem_value(req_elem),
        .i_anchor_value(req_anchor),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_out_value(res_value), .o_status(res_status),
        .o_node_total(res_total), .o_last_flag(res_last)
    );

    linked_list_sequence_store_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .i_in_ready(req_ready),
        .i_req_type(req_type), .i_elem_value(req_elem),
        .i_anchor_value(req_anchor),
        .i_out_valid(res_valid), .i_ready(res_ready),
        .i_out_value(res_value), .i_status(res_status),
        .i_node_total(res_total), .i_last_flag(res_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 2) != 0) return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Offers one transaction and waits until the block takes it. Valid is
    // left high afterwards; the caller lowers it only when a gap follows.
    task automatic send_request(input logic [3:0] kind, input logic [31:0] ev,
                                input logic [31:0] av);
        req_valid <= 1'b1;
        req_type <= kind;
        req_elem <= ev;
        req_anchor <= av;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic idle_request(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_request(1);
        while (pending != 0) @(posedge clk);
        // The block may still be finishing a request that gave no result.
        repeat (200) @(posedge clk);
    endtask

    // Long consumer hold, counted here in cycles once the stimulus asks.
    initial begin
        hold_consumer = 1'b0;
        @(start_hold);
        hold_consumer = 1'b1;
        repeat (300) @(posedge clk);
        hold_consumer = 1'b0;
    end

    // Consumer: random stalls with stretches of steady acceptance, plus the
    // long hold when asked.
    always @(posedge clk) begin
        if (!rst_n || hold_consumer) begin
            res_ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 3) begin
            res_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        int burst;
        int sent;
        int dice;
        logic [3:0] kind;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = '0;
        req_elem = '0;
        req_anchor = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-list cases first, then the extremes.
        send_request(llss_pkg::REQ_DEL_REAR, '0, '0);
        send_request(llss_pkg::REQ_DEL_FRONT, '0, '0);
        send_request(llss_pkg::REQ_DEL_VALUE, 32'd5, '0);
        send_request(llss_pkg::REQ_LIST, '0, '0);
        send_request(llss_pkg::REQ_REVERSE, '0, '0);
        send_request(llss_pkg::REQ_COUNT, '0, '0);
        send_request(llss_pkg::REQ_INS_AFTER, 32'h8000_0000, 32'h1234);
        send_request(llss_pkg::REQ_INS_FRONT, 32'h7FFF_FFFF, '0);
        send_request(llss_pkg::REQ_INS_REAR, 32'hFFFF_FFFF, '0);
        send_request(llss_pkg::REQ_INS_AFTER, 32'h0, 32'h7FFF_FFFF);
        send_request(llss_pkg::REQ_INS_AFTER, 32'h3, 32'h5);
        send_request(llss_pkg::REQ_DEL_VALUE, 32'h77, '0);
        send_request(4'd9, '0, '0);
        send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(llss_pkg::REQ_LIST, '0, '0);
        send_request(llss_pkg::REQ_REVERSE, '0, '0);
        send_request(llss_pkg::REQ_DEL_VALUE, 32'h0, '0);
        send_request(llss_pkg::REQ_DEL_REAR, '0, '0);
        send_request(llss_pkg::REQ_DEL_FRONT, '0, '0);
        send_request(llss_pkg::REQ_COUNT, '0, '0);
        wait_drained();

        // Fill the store to capacity while the consumer holds off, then
        // check the full answer for every insert kind.
        -> start_hold;
        for (int i = 0; i < llss_pkg::CAPACITY_DEF; i++)
            send_request(llss_pkg::REQ_INS_REAR, pick_value(), '0);
        send_request(llss_pkg::REQ_INS_FRONT, 32'd1, '0);
        send_request(llss_pkg::REQ_INS_REAR, 32'd1, '0);
        send_request(llss_pkg::REQ_INS_AFTER, 32'd1, value_pool[0]);
        send_request(llss_pkg::REQ_REVERSE, '0, '0);
        send_request(llss_pkg::REQ_LIST, '0, '0);
        wait_drained();

        // Random part: bursts with gaps. Inserts are drawn more often than deletes;
        // the mix also holds counts, listings, reverses and unknown codes.
        sent = 0;
        while (sent < 190) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                dice = $urandom_range(0, 99);
                if (dice < 40) kind = 4'($urandom_range(0, 1));
                else if (dice < 55) kind = llss_pkg::REQ_INS_AFTER;
                else if (dice < 85) kind = 4'($urandom_range(4, 6));
                else if (dice < 90) kind = llss_pkg::REQ_COUNT;
                else if (dice < 94) kind = llss_pkg::REQ_LIST;
                else if (dice < 97) kind = llss_pkg::REQ_REVERSE;
                else kind = 4'($urandom_range(9, 15));
                send_request(kind, pick_value(), pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_request($urandom_range(1, 20));
            if (sent > 90 && sent < 103) wait_drained();
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("PASS linked_list_sequence_store");
        end else begin
            $display("FAIL linked_list_sequence_store");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL linked_list_sequence_store");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/llss_pkg.sv
rtl/llss_node_store.sv
rtl/linked_list_sequence_store.sv
sim/linked_list_sequence_store_checker.sv
sim/linked_list_sequence_store_test.sv
